FILE: design/gyro_bias_calibrate_integrate_assert.svh
// Assertion macros shared by the gyro bias calibration checkers.
`ifndef GYRO_BIAS_CALIBRATE_INTEGRATE_ASSERT_SVH
`define GYRO_BIAS_CALIBRATE_INTEGRATE_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define GBI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define GBI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/gbi_pkg.sv
// Shared types, codes and widths for the gyro bias calibration block.
package gbi_pkg;

  // Field widths
  localparam int OP_W       = 3;
  localparam int SAMPLE_W   = 16;
  localparam int LEVEL_W    = 24;
  localparam int DIFF_W     = LEVEL_W + 1;
  localparam int DIFF_MAG_W = LEVEL_W;
  localparam int GAIN_W     = 32;
  localparam int PROD_W     = DIFF_MAG_W + GAIN_W;
  localparam int ACC_W      = 64;
  localparam int ANGLE_W    = 48;
  localparam int ANGLE_LSB  = 16;
  localparam int MODE_W     = 2;
  localparam int CNT_W      = 5;
  localparam int ITER_W     = 5;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 80;

  // Default number of calibration samples
  localparam int CAL_SAMPLES_DEF = 20;

  // Null level after reset: 0.7576 of full scale
  localparam logic [LEVEL_W-1:0] NULL_RESET = 24'd12710419;

  // Last iteration index of the serial units
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(DIFF_MAG_W - 1);

  // Event codes
  localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
  localparam logic [OP_W-1:0] OP_ZERO    = 3'd1;
  localparam logic [OP_W-1:0] OP_CAL     = 3'd2;
  localparam logic [OP_W-1:0] OP_ENABLE  = 3'd3;
  localparam logic [OP_W-1:0] OP_DISABLE = 3'd4;

  // Run modes
  localparam logic [MODE_W-1:0] MODE_IDLE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CAL  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RUN  = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_t;

endpackage

FILE: design/gbi_mul.sv
// Shift-add serial multiplier: one multiplier bit per cycle.
module gbi_mul import gbi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIFF_MAG_W-1:0] mplier,
  input  logic [GAIN_W-1:0]     mcand,
  output logic                  done,
  output logic [PROD_W-1:0]     product
);

  logic                  busy;
  logic [ITER_W-1:0]     cnt;
  logic [GAIN_W-1:0]     hi;
  logic [DIFF_MAG_W-1:0] lo;
  logic [GAIN_W-1:0]     mcand_r;
  logic [GAIN_W:0]       add_sum;

  // Add the multiplicand into the upper half when the current bit is set
  always_comb begin
    add_sum = {1'b0, hi} + (lo[0] ? {1'b0, mcand_r} : '0);
  end

  // Sequence the iterations
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == ITER_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift the partial product right one bit per step
  always_ff @(posedge clk) begin
    if (start) begin
      hi      <= '0;
      lo      <= mplier;
      mcand_r <= mcand;
    end else if (busy) begin
      {hi, lo} <= {add_sum, lo[DIFF_MAG_W-1:1]};
    end
  end

  assign product = {hi, lo};

endmodule

FILE: design/gbi_div.sv
// Restoring serial divider: one quotient bit per cycle.
module gbi_div import gbi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIFF_MAG_W-1:0] dividend,
  input  logic [CNT_W-1:0]      divisor,
  output logic                  done,
  output logic [DIFF_MAG_W-1:0] quotient
);

  logic                  busy;
  logic [ITER_W-1:0]     cnt;
  logic [CNT_W-1:0]      rem;
  logic [DIFF_MAG_W-1:0] quo;
  logic [CNT_W-1:0]      dvs;
  logic [CNT_W:0]        trial;
  logic [CNT_W:0]        trial_sub;
  logic                  ge;

  // Bring down the next dividend bit and try the subtraction
  always_comb begin
    trial     = {rem, quo[DIFF_MAG_W-1]};
    trial_sub = trial - {1'b0, dvs};
    ge        = (trial >= {1'b0, dvs});
  end

  // Sequence the iterations
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == ITER_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift quotient bits in as dividend bits leave
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
      quo <= {quo[DIFF_MAG_W-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

FILE: design/gyro_bias_calibrate_integrate.sv
// Top level: gyro bias calibration and rate integration sequencer.
// Events and ticks that need no arithmetic pass from accept through dispatch
// to the finish state; integrating and averaging ticks also pass through the
// 24-step serial multiplier or divider. One request is in work at a time, so
// no new request is taken until the last result is loaded for output.
// Synchronous reset clears the angle, count, mode and gain and loads the
// default null level; the block accepts requests right after reset.
module gyro_bias_calibrate_integrate import gbi_pkg::*; #(
  parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [GAIN_W-1:0]     cfg_wr_data,   // scale_gain
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,       // [15:0] rate_sample
  input  logic [OP_W-1:0]       s_tuser,       // [2:0] op
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [47:0] angle, [71:48] null_level, [73:72] mode, [74] sample_applied,
  // [79:75] zero
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam logic [CNT_W-1:0] CAL_LIMIT = CNT_W'(CAL_SAMPLES);

  state_t state, state_next;

  // Architectural state
  logic signed [GAIN_W-1:0] scale_gain;
  logic [ACC_W-1:0]         angle_acc, angle_next;
  logic [LEVEL_W-1:0]       null_acc, null_next;
  logic [CNT_W-1:0]         cal_count, count_next;
  logic [MODE_W-1:0]        run_mode, mode_next;
  logic                     applied_next;

  // Request held while in work
  logic [OP_W-1:0]     op_r;
  logic [SAMPLE_W-1:0] sample_r;

  // Datapath
  logic [LEVEL_W-1:0]    level;
  logic [DIFF_W-1:0]     diff;
  logic [DIFF_W-1:0]     diff_abs;
  logic                  diff_neg;
  logic [DIFF_MAG_W-1:0] diff_mag;
  logic                  gain_neg;
  logic [GAIN_W-1:0]     gain_mag;
  logic [CNT_W-1:0]      count_inc;
  logic                  need_mul, need_div, slot_free;
  logic                  mul_start, div_start, commit;
  logic                  mul_done, div_done;
  logic [PROD_W-1:0]     product;
  logic [DIFF_MAG_W-1:0] quotient;
  logic [ACC_W:0]        prod_ext, addend, sum_ext;
  logic [ACC_W-1:0]      sat_sum;
  logic [DIFF_W-1:0]     q_ext, q_signed, null_sum;

  // Form the signed difference and the operand magnitudes
  always_comb begin
    level     = {sample_r, 8'h00};
    diff      = {1'b0, level} - {1'b0, null_acc};
    diff_neg  = diff[DIFF_W-1];
    diff_abs  = diff_neg ? (~diff + 1'b1) : diff;
    diff_mag  = diff_abs[DIFF_MAG_W-1:0];
    gain_neg  = scale_gain[GAIN_W-1];
    gain_mag  = gain_neg ? (~scale_gain + 1'b1) : scale_gain;
    count_inc = cal_count + 1'b1;
    need_mul  = (op_r == OP_TICK) && (run_mode == MODE_RUN);
    need_div  = (op_r == OP_TICK) && (run_mode == MODE_CAL) &&
                (cal_count < CAL_LIMIT) && (cal_count != '0);
    slot_free = !m_tvalid || m_tready;
  end

  // Apply the product sign and saturate the accumulator sum
  always_comb begin
    prod_ext = {{(ACC_W + 1 - PROD_W){1'b0}}, product};
    addend   = (diff_neg ^ gain_neg) ? (~prod_ext + 1'b1) : prod_ext;
    sum_ext  = {angle_acc[ACC_W-1], angle_acc} + addend;
    if (sum_ext[ACC_W] != sum_ext[ACC_W-1]) begin
      sat_sum = sum_ext[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sat_sum = sum_ext[ACC_W-1:0];
    end
  end

  // Step the running mean by the signed quotient
  always_comb begin
    q_ext    = {1'b0, quotient};
    q_signed = diff_neg ? (~q_ext + 1'b1) : q_ext;
    null_sum = {1'b0, null_acc} + q_signed;
  end

  // Work out the state after the request
  always_comb begin
    angle_next   = angle_acc;
    null_next    = null_acc;
    count_next   = cal_count;
    mode_next    = run_mode;
    applied_next = 1'b0;
    case (op_r)
      OP_TICK: begin
        if (run_mode == MODE_RUN) begin
          angle_next   = sat_sum;
          applied_next = 1'b1;
        end else if (run_mode == MODE_CAL) begin
          if (cal_count >= CAL_LIMIT) begin
            mode_next = MODE_IDLE;
          end else begin
            count_next = count_inc;
            null_next  = (cal_count == '0) ? level : null_sum[LEVEL_W-1:0];
          end
        end
      end
      OP_ZERO: begin
        angle_next = '0;
      end
      OP_CAL: begin
        mode_next  = MODE_CAL;
        count_next = '0;
      end
      OP_ENABLE: begin
        angle_next = '0;
        if (run_mode == MODE_IDLE) begin
          mode_next = MODE_RUN;
        end
      end
      OP_DISABLE: begin
        if (run_mode != MODE_IDLE) begin
          mode_next  = MODE_IDLE;
          angle_next = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (s_tvalid) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        if (need_mul) begin
          state_next = ST_MUL;
        end else if (need_div) begin
          state_next = ST_DIV;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_MUL:      if (mul_done) state_next = ST_FIN;
      ST_DIV:      if (div_done) state_next = ST_FIN;
      ST_FIN:      if (slot_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_tready  = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    commit    = 1'b0;
    case (state)
      ST_IDLE:     s_tready = 1'b1;
      ST_DISPATCH: begin
        mul_start = need_mul;
        div_start = !need_mul && need_div;
      end
      ST_FIN:      commit = slot_free;
      default: begin
      end
    endcase
  end

  // Advance the sequencer and the architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      scale_gain <= '0;
      angle_acc  <= '0;
      null_acc   <= NULL_RESET;
      cal_count  <= '0;
      run_mode   <= MODE_IDLE;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        scale_gain <= cfg_wr_data;
      end
      if (commit) begin
        angle_acc <= angle_next;
        null_acc  <= null_next;
        cal_count <= count_next;
        run_mode  <= mode_next;
      end
    end
  end

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_r     <= s_tuser;
      sample_r <= s_tdata[SAMPLE_W-1:0];
    end
  end

  // Output register: load on commit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tdata <= {{(OUT_DATA_W - ANGLE_W - LEVEL_W - MODE_W - 1){1'b0}},
                  applied_next, mode_next, null_next,
                  angle_next[ANGLE_LSB +: ANGLE_W]};
    end
  end

  gbi_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mplier  (diff_mag),
    .mcand   (gain_mag),
    .done    (mul_done),
    .product (product)
  );

  gbi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (diff_mag),
    .divisor  (count_inc),
    .done     (div_done),
    .quotient (quotient)
  );

endmodule

FILE: design/gbi_checker.sv
// Port-level checker for the gyro bias calibration block, with its bind.
`include "gyro_bias_calibrate_integrate_assert.svh"

module gbi_checker import gbi_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // A sample is only integrated while the block is integrating
  `GBI_ASSERT_NOW(a_applied_in_run, m_tvalid && m_tdata[74], m_tdata[73:72] == MODE_RUN, "sample applied outside run mode")

  // One request in work at a time: no accept right after an accept
  `GBI_ASSERT_NEXT(a_one_in_work, s_tvalid && s_tready, !s_tready, "request accepted while another is in work")

  // A stalled result holds
  `GBI_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind gyro_bias_calibrate_integrate gbi_checker u_checker (.*);

FILE: test/tb.sv
// Testbench for the gyro bias calibration and rate integration block.
module tb import gbi_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // Spare event codes that the block must ignore
  localparam logic [OP_W-1:0] OP_SPARE5 = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

  localparam logic [GAIN_W-1:0] GAIN_MAX = 32'h7FFF_FFFF;
  localparam logic [GAIN_W-1:0] GAIN_MIN = 32'h8000_0000;
  localparam logic [GAIN_W-1:0] GAIN_NEG_ONE = 32'hFFFF_FFFF;

  localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint ACC_MIN = 64'sh8000_0000_0000_0000;

  localparam int SETTLE_CYCLES = 32;
  localparam int CYCLE_LIMIT = 600000;
  localparam int REPORT_MAX = 10;

  typedef struct {
    logic [OP_W-1:0]     op;
    logic [SAMPLE_W-1:0] reading;
  } gyro_req_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic [LEVEL_W-1:0] null_level;
    logic [MODE_W-1:0]  mode;
    logic               applied;
  } angle_report_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [GAIN_W-1:0]     cfg_wr_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // [15:0] rate_sample
  logic [OP_W-1:0]       s_tuser = '0;   // [2:0] op
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // [47:0] angle, [71:48] null_level, [73:72] mode, [74] sample_applied, [79:75] zero
  logic [OUT_DATA_W-1:0] m_tdata;

  gyro_req_t     request_q[$];
  angle_report_t report_q[$];
  logic          req_fire = 1'b0;
  bit            calm = 1'b0;

  // Predicted block state
  longint            model_angle = 0;
  logic [LEVEL_W-1:0] model_null = NULL_RESET;
  int                model_cal_cnt = 0;
  logic [MODE_W-1:0] model_mode = MODE_IDLE;
  int                model_gain = 0;

  int n_requests = 0;
  int n_results = 0;
  int n_applied = 0;
  int n_cal_done = 0;
  int n_saturated = 0;
  int n_errors = 0;
  int n_cycles = 0;

  gyro_bias_calibrate_integrate dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Advance the predicted state by one request and return the expected result
  function automatic angle_report_t step_gyro(logic [OP_W-1:0] op,
                                              logic [SAMPLE_W-1:0] reading);
    longint level;
    longint diff;
    longint incr;
    logic signed [ACC_W:0] total;
    angle_report_t r;
    r.applied = 1'b0;
    level = longint'({reading, 8'h00});
    diff = level - longint'(model_null);
    case (op)
      OP_TICK: begin
        if (model_mode == MODE_RUN) begin
          incr = diff * longint'(model_gain);
          total = {model_angle[63], model_angle} + {incr[63], incr};
          if (total[ACC_W] != total[ACC_W-1]) begin
            model_angle = total[ACC_W] ? ACC_MIN : ACC_MAX;
            n_saturated++;
          end else begin
            model_angle = total[ACC_W-1:0];
          end
          r.applied = 1'b1;
          n_applied++;
        end else if (model_mode == MODE_CAL) begin
          if (model_cal_cnt >= CAL_SAMPLES_DEF) begin
            // calibration over: drop the sample and go idle
            model_mode = MODE_IDLE;
            n_cal_done++;
          end else begin
            model_cal_cnt++;
            if (model_cal_cnt == 1) model_null = level[LEVEL_W-1:0];
            else model_null = LEVEL_W'(longint'(model_null) + diff / longint'(model_cal_cnt));
          end
        end
      end
      OP_ZERO: model_angle = 0;
      OP_CAL: begin
        model_mode = MODE_CAL;
        model_cal_cnt = 0;
      end
      OP_ENABLE: begin
        model_angle = 0;
        if (model_mode == MODE_IDLE) model_mode = MODE_RUN;
      end
      OP_DISABLE: begin
        if (model_mode != MODE_IDLE) begin
          model_mode = MODE_IDLE;
          model_angle = 0;
        end
      end
      default: ;
    endcase
    r.angle = ANGLE_W'(model_angle >>> ANGLE_LSB);
    r.null_level = model_null;
    r.mode = model_mode;
    return r;
  endfunction

  // Request side: present the next pending request, hold it until taken
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || req_fire) begin
      if (request_q.size() != 0 && (calm || $urandom_range(99) >= 20)) begin
        s_tvalid <= 1'b1;
        s_tuser <= request_q[0].op;
        s_tdata <= request_q[0].reading;
      end else begin
        s_tvalid <= 1'b0;
        s_tuser <= OP_W'($urandom);
        s_tdata <= IN_DATA_W'($urandom);
      end
    end
  end

  // Track gain writes and accepted requests, predict each result
  always @(posedge clk) begin
    req_fire <= !rst && s_tvalid && s_tready;
    if (!rst && cfg_wr_en) model_gain = int'(cfg_wr_data);
    if (!rst && s_tvalid && s_tready) begin
      report_q.push_back(step_gyro(s_tuser, s_tdata));
      void'(request_q.pop_front());
      n_requests++;
    end
  end

  // Result side: stall at random
  always @(negedge clk) begin
    m_tready <= !rst && (calm || $urandom_range(99) >= 20);
  end

  // Compare each result with the oldest prediction
  always @(posedge clk) begin
    angle_report_t got;
    angle_report_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.angle = m_tdata[47:0];
      got.null_level = m_tdata[71:48];
      got.mode = m_tdata[73:72];
      got.applied = m_tdata[74];
      n_results++;
      if (report_q.size() == 0) begin
        n_errors++;
        if (n_errors <= REPORT_MAX)
          $display("ERROR: unexpected result angle=%h null=%h mode=%0d applied=%0b",
                   got.angle, got.null_level, got.mode, got.applied);
      end else begin
        want = report_q.pop_front();
        if (got !== want) begin
          n_errors++;
          if (n_errors <= REPORT_MAX)
            $display({"ERROR: result %0d expected angle=%h null=%h mode=%0d applied=%0b,",
                      " got angle=%h null=%h mode=%0d applied=%0b"}, n_results,
                     want.angle, want.null_level, want.mode, want.applied,
                     got.angle, got.null_level, got.mode, got.applied);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", n_cycles,
               report_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic push_req(logic [OP_W-1:0] op, logic [SAMPLE_W-1:0] reading);
    gyro_req_t r;
    r.op = op;
    r.reading = reading;
    request_q.push_back(r);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_reading();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 20) return '1;
    return SAMPLE_W'($urandom);
  endfunction

  // Write the gain while the block is idle
  task automatic write_gain(logic [GAIN_W-1:0] gain);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= gain;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= GAIN_W'($urandom);
  endtask

  // Wait until every request is taken and every result is back
  task automatic settle();
    while (request_q.size() != 0 || s_tvalid || report_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Queue mostly well-formed calibrate and integrate sessions, some noise
  task automatic queue_sessions(int target);
    int start;
    int roll;
    int n;
    start = request_q.size();
    while (request_q.size() - start < target) begin
      roll = $urandom_range(99);
      if (roll < 35) begin
        push_req(OP_CAL, pick_reading());
        n = ($urandom_range(99) < 80) ? CAL_SAMPLES_DEF : $urandom_range(CAL_SAMPLES_DEF - 1);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(99) < 5) push_req(($urandom_range(1)) ? OP_ENABLE : OP_ZERO, '0);
          push_req(OP_TICK, pick_reading());
        end
        if (n == CAL_SAMPLES_DEF) begin
          push_req(OP_TICK, pick_reading());
          if ($urandom_range(1)) push_req(OP_TICK, pick_reading());
        end else begin
          push_req(($urandom_range(1)) ? OP_DISABLE : OP_CAL, pick_reading());
        end
      end else if (roll < 80) begin
        push_req(OP_ENABLE, pick_reading());
        n = $urandom_range(1, 40);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(99) < 8) push_req(($urandom_range(1)) ? OP_ZERO : OP_ENABLE, '0);
          else push_req(OP_TICK, pick_reading());
        end
        if ($urandom_range(1)) push_req(OP_DISABLE, pick_reading());
      end else begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) push_req(OP_W'($urandom), SAMPLE_W'($urandom));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: spare codes, events in idle, integrating and calibrating modes, field extremes
    write_gain(GAIN_NEG_ONE);
    push_req(OP_SPARE5, 16'hFFFF);
    push_req(OP_SPARE6, 16'h5555);
    push_req(OP_SPARE7, 16'hAAAA);
    push_req(OP_TICK, 16'hFFFF);      // tick while idle
    push_req(OP_DISABLE, 16'h0000);   // disable while idle
    push_req(OP_ZERO, 16'h0000);
    push_req(OP_ENABLE, 16'h0000);    // idle to integrating
    push_req(OP_TICK, 16'hFFFF);
    push_req(OP_TICK, 16'h0000);
    push_req(OP_TICK, 16'h8000);
    push_req(OP_ENABLE, 16'h0000);    // while integrating: clear angle only
    push_req(OP_TICK, 16'h7FFF);
    push_req(OP_ZERO, 16'h0000);
    push_req(OP_TICK, 16'h0001);
    push_req(OP_CAL, 16'h0000);       // from integrating
    push_req(OP_TICK, 16'hFFFF);
    push_req(OP_TICK, 16'h0000);
    push_req(OP_ENABLE, 16'h0000);    // while calibrating
    push_req(OP_TICK, 16'h1234);
    push_req(OP_DISABLE, 16'h0000);   // while calibrating
    push_req(OP_ENABLE, 16'hFFFF);
    push_req(OP_DISABLE, 16'h0000);   // while integrating
    settle();

    // Drive the accumulator into its positive limit from a zero null level
    write_gain(GAIN_MAX);
    push_req(OP_CAL, 16'h0000);
    repeat (CAL_SAMPLES_DEF) push_req(OP_TICK, 16'h0000);
    push_req(OP_TICK, 16'hFFFF);      // ends calibration
    push_req(OP_TICK, 16'hFFFF);      // idle again
    push_req(OP_ENABLE, 16'h0000);
    repeat (270) push_req(OP_TICK, 16'hFFFF);
    settle();

    // Same toward the negative limit
    write_gain(GAIN_MIN);
    push_req(OP_ZERO, 16'h0000);
    repeat (270) push_req(OP_TICK, 16'hFFFF);
    push_req(OP_TICK, pick_reading());
    push_req(OP_DISABLE, 16'h0000);
    settle();

    write_gain('0);
    queue_sessions(250);
    settle();

    // No idling on either side here
    write_gain(GAIN_W'($urandom));
    calm = 1'b1;
    queue_sessions(420);
    settle();
    calm = 1'b0;

    write_gain(GAIN_W'($urandom_range(4000)) - 32'd2000);
    queue_sessions(400);
    settle();

    $display("Covered %0d requests and %0d results over six gain settings.",
             n_requests, n_results);
    $display("Integrated %0d ticks, %0d saturated, %0d calibrations completed, %0d mismatches.",
             n_applied, n_saturated, n_cal_done, n_errors);
    if (n_errors == 0 && report_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
